/* rtl/core/bhct_pkg.sv */
// ----------------------------------------------------------------------------
// bhct_pkg
// Types and codes shared by the blink-hold command trigger.
// ----------------------------------------------------------------------------
package bhct_pkg;

  localparam int unsigned CFG_W = 8;   // width of the tick registers

  // opcodes of an input transaction
  localparam logic [1:0] OP_BLINK  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // status report codes
  localparam logic [1:0] ST_PICK_OK  = 2'd0;
  localparam logic [1:0] ST_PLACE_OK = 2'd1;

  // result actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_BEEP  = 2'd1;
  localparam logic [1:0] ACT_PICK  = 2'd2;
  localparam logic [1:0] ACT_PLACE = 2'd3;

  // configuration register indexes
  localparam logic REG_HOLD_TICKS  = 1'b0;
  localparam logic REG_DELAY_TICKS = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic       eye_closed_sample;
    logic [1:0] status_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       object_held;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic pending;
  } ctrl_status_t;

endpackage

/* rtl/core/bhct_chan_if.sv */
// ----------------------------------------------------------------------------
// bhct_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface bhct_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/blink_hold_command_trigger.sv */
// ----------------------------------------------------------------------------
// blink_hold_command_trigger
// Turns eye-blink samples and timer ticks into beep and pick/place commands.
// ----------------------------------------------------------------------------
//  port     dir  kind         payload
//  in_ch    in   valid/ready  opcode, eye_closed_sample, status_code
//  out_ch   out  valid/ready  action, object_held
//  cfg_*    in   write only   index 0 hold_ticks, index 1 delay_ticks
//
// One transaction per cycle unless out_ch stalls; its result is in the output
// register the cycle after acceptance, state update and decode in one pass.
// in_ch.ready stays high while the output register is empty or being drained.
// rst_n is synchronous: all flags and counters clear, registers load 75 / 38.
// ----------------------------------------------------------------------------
module blink_hold_command_trigger #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bhct_chan_if.sink                  in_ch,
  bhct_chan_if.source                out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bhct_pkg::CFG_W-1:0] cfg_wdata
);

  logic [bhct_pkg::CFG_W-1:0] hold_ticks_r;
  logic [bhct_pkg::CFG_W-1:0] delay_ticks_r;
  logic                       out_valid_r;
  bhct_pkg::out_item_t        out_data_r;
  bhct_pkg::out_item_t        result;
  bhct_pkg::ctrl_status_t     status;
  logic                       in_ready;
  logic                       in_acc;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r  <= bhct_pkg::CFG_W'(75);
      delay_ticks_r <= bhct_pkg::CFG_W'(38);
    end else if (cfg_we) begin
      if (cfg_index == bhct_pkg::REG_HOLD_TICKS) begin
        hold_ticks_r <= cfg_wdata;
      end else if (cfg_index == bhct_pkg::REG_DELAY_TICKS) begin
        delay_ticks_r <= cfg_wdata;
      end
    end
  end

  bhct_ctrl #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (in_acc),
    .item        (in_ch.data),
    .hold_ticks  (hold_ticks_r),
    .delay_ticks (delay_ticks_r),
    .result      (result),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= result;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef NO_ASSERTIONS
  // busy is only entered from the pending phase and both leave together
  a_busy_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> status.pending)
    else $error("busy without pending command");

  // a pick is issued only with no object held, a place only with one held
  a_cmd_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.data.action == bhct_pkg::ACT_PICK ||
                      out_ch.data.action == bhct_pkg::ACT_PLACE))
    |-> (out_ch.data.object_held == (out_ch.data.action == bhct_pkg::ACT_PLACE)))
    else $error("command does not match held flag");

  // while busy, a tick produces no action
  a_busy_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status.busy && in_ch.data.opcode == bhct_pkg::OP_TICK)
    |=> (out_ch.valid && out_ch.data.action == bhct_pkg::ACT_NONE))
    else $error("action emitted while busy");
`endif

endmodule

/* rtl/core/bhct_ctrl.sv */
// ----------------------------------------------------------------------------
// bhct_ctrl
// Blink/hold/delay state and the next-state logic for one transaction.
// ----------------------------------------------------------------------------
module bhct_ctrl #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_en,
  input  bhct_pkg::in_item_t          item,
  input  logic [bhct_pkg::CFG_W-1:0]  hold_ticks,
  input  logic [bhct_pkg::CFG_W-1:0]  delay_ticks,
  output bhct_pkg::out_item_t         result,
  output bhct_pkg::ctrl_status_t      status
);

  localparam int unsigned CMP_W = (COUNTER_BITS > bhct_pkg::CFG_W) ?
                                  COUNTER_BITS : bhct_pkg::CFG_W;

  logic eye_r, eye_nxt;
  logic changed_r, changed_nxt;
  logic timing_r, timing_nxt;
  logic beep_r, beep_nxt;
  logic pending_r, pending_nxt;
  logic held_r, held_nxt;
  logic busy_r, busy_nxt;
  logic [COUNTER_BITS-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [COUNTER_BITS-1:0] delay_cnt_r, delay_cnt_nxt;

  logic [COUNTER_BITS-1:0] hold_inc, delay_inc;
  logic                    hold_met, delay_met;
  logic [1:0]              act;

  // saturating increments
  assign hold_inc  = (hold_cnt_r == '1)  ? hold_cnt_r  : hold_cnt_r + 1'b1;
  assign delay_inc = (delay_cnt_r == '1) ? delay_cnt_r : delay_cnt_r + 1'b1;

  assign hold_met  = CMP_W'(hold_inc)  >= CMP_W'(hold_ticks);
  assign delay_met = CMP_W'(delay_inc) >= CMP_W'(delay_ticks);

  always_comb begin
    eye_nxt       = eye_r;
    changed_nxt   = changed_r;
    timing_nxt    = timing_r;
    beep_nxt      = beep_r;
    pending_nxt   = pending_r;
    held_nxt      = held_r;
    busy_nxt      = busy_r;
    hold_cnt_nxt  = hold_cnt_r;
    delay_cnt_nxt = delay_cnt_r;
    act           = bhct_pkg::ACT_NONE;

    unique case (item.opcode)
      bhct_pkg::OP_BLINK: begin
        if (!busy_r) begin
          eye_nxt     = item.eye_closed_sample;
          changed_nxt = 1'b1;
        end
      end
      bhct_pkg::OP_STATUS: begin
        if (item.status_code == bhct_pkg::ST_PICK_OK) begin
          held_nxt = 1'b1;
        end else if (item.status_code == bhct_pkg::ST_PLACE_OK) begin
          held_nxt = 1'b0;
        end
        pending_nxt = 1'b0;
        busy_nxt    = 1'b0;
      end
      bhct_pkg::OP_TICK: begin
        if (!busy_r) begin
          changed_nxt = 1'b0;
          if (pending_r) begin
            delay_cnt_nxt = delay_inc;
            if (delay_met) begin
              act        = held_r ? bhct_pkg::ACT_PLACE : bhct_pkg::ACT_PICK;
              timing_nxt = 1'b0;
              busy_nxt   = 1'b1;
            end
          end else begin
            if (timing_r) begin
              hold_cnt_nxt = hold_inc;
            end
            if (timing_r && hold_met) begin
              if (!beep_r) begin
                act      = bhct_pkg::ACT_BEEP;
                beep_nxt = 1'b1;
              end else if (!eye_r) begin
                // eye reopened after the beep: start the delay
                delay_cnt_nxt = '0;
                pending_nxt   = 1'b1;
                beep_nxt      = 1'b0;
              end
            end else if (!eye_r) begin
              timing_nxt = 1'b0;
            end else if (changed_r) begin
              hold_cnt_nxt = '0;
              timing_nxt   = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r       <= 1'b0;
      changed_r   <= 1'b0;
      timing_r    <= 1'b0;
      beep_r      <= 1'b0;
      pending_r   <= 1'b0;
      held_r      <= 1'b0;
      busy_r      <= 1'b0;
      hold_cnt_r  <= '0;
      delay_cnt_r <= '0;
    end else if (item_en) begin
      eye_r       <= eye_nxt;
      changed_r   <= changed_nxt;
      timing_r    <= timing_nxt;
      beep_r      <= beep_nxt;
      pending_r   <= pending_nxt;
      held_r      <= held_nxt;
      busy_r      <= busy_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      delay_cnt_r <= delay_cnt_nxt;
    end
  end

  assign result.action      = act;
  assign result.object_held = held_nxt;
  assign status.busy        = busy_r;
  assign status.pending     = pending_r;

endmodule

/* tb/blink_hold_command_trigger_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blink_hold_command_trigger_tb
// Drives blink samples, status reports and ticks through the valid/ready
// input channel with random gaps and output stalls. A predictor of the
// trigger computes one expected result per accepted transaction, and every
// result is checked field by field against it or a typed-in expectation.
// The tick registers are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module blink_hold_command_trigger_tb;

  localparam int unsigned CNT_BITS    = 8;
  localparam logic [7:0]  HOLD_RESET  = 8'd75;
  localparam logic [7:0]  DELAY_RESET = 8'd38;
  localparam logic [1:0]  ST_FAILED   = 2'd2;
  localparam logic [1:0]  ST_SPARE    = 2'd3;

  typedef enum logic { ROW_TXN, ROW_REGS } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    bhct_pkg::in_item_t   item;
    bit                   known;   // expected result typed in rather than predicted
    bhct_pkg::out_item_t  want;
    logic [7:0]           hold;
    logic [7:0]           delay;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         src_valid = 1'b0;
  bhct_pkg::in_item_t           src_data = '0;
  logic                         sink_ready = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = bhct_pkg::REG_HOLD_TICKS;
  logic [bhct_pkg::CFG_W-1:0]   cfg_wdata = '0;

  bhct_chan_if #(.T(bhct_pkg::in_item_t))  in_ch ();
  bhct_chan_if #(.T(bhct_pkg::out_item_t)) out_ch ();

  assign in_ch.valid  = src_valid;
  assign in_ch.data   = src_data;
  assign out_ch.ready = sink_ready;

  blink_hold_command_trigger #(.COUNTER_BITS(CNT_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [7:0]          hold_reg, delay_reg;
  bit                  eye_closed, blink_seen, hold_run, beep_given;
  bit                  cmd_pending, held, busy;
  logic [CNT_BITS-1:0] hold_cnt, delay_cnt;

  bhct_pkg::out_item_t pending_actions[$];
  int unsigned         errors;
  int unsigned         played;
  int unsigned         sink_stall;
  bit                  quiet;
  bhct_pkg::out_item_t seen_want;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic bhct_pkg::out_item_t advance_trigger(input bhct_pkg::in_item_t it);
    bhct_pkg::out_item_t r;
    bit                  reached;
    r.action = bhct_pkg::ACT_NONE;
    reached  = 1'b0;
    case (it.opcode)
      bhct_pkg::OP_BLINK: begin
        if (!busy) begin
          eye_closed = it.eye_closed_sample;
          blink_seen = 1'b1;
        end
      end
      bhct_pkg::OP_STATUS: begin
        if (it.status_code == bhct_pkg::ST_PICK_OK) held = 1'b1;
        else if (it.status_code == bhct_pkg::ST_PLACE_OK) held = 1'b0;
        cmd_pending = 1'b0;
        busy        = 1'b0;
      end
      bhct_pkg::OP_TICK: begin
        if (!busy) begin
          if (cmd_pending) begin
            delay_cnt = sat_inc(delay_cnt);
            if (delay_cnt >= delay_reg) begin
              r.action = held ? bhct_pkg::ACT_PLACE : bhct_pkg::ACT_PICK;
              hold_run = 1'b0;
              busy     = 1'b1;
            end
          end else begin
            if (hold_run) begin
              hold_cnt = sat_inc(hold_cnt);
              reached  = (hold_cnt >= hold_reg);
            end
            if (reached) begin
              if (!beep_given) begin
                r.action   = bhct_pkg::ACT_BEEP;
                beep_given = 1'b1;
              end else if (!eye_closed) begin
                delay_cnt   = '0;
                cmd_pending = 1'b1;
                beep_given  = 1'b0;
              end
            end else if (!eye_closed) begin
              hold_run = 1'b0;
            end else if (blink_seen) begin
              hold_cnt = '0;
              hold_run = 1'b1;
            end
          end
          blink_seen = 1'b0;
        end
      end
      default: ;
    endcase
    r.object_held = held;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic bhct_pkg::in_item_t mk(input logic [1:0] op, input logic s);
    bhct_pkg::in_item_t it;
    it.opcode            = op;
    it.eye_closed_sample = s;
    it.status_code       = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input logic s,
                                   input logic [1:0] st);
    dir_row_t d;
    d.kind                   = ROW_TXN;
    d.item.opcode            = op;
    d.item.eye_closed_sample = s;
    d.item.status_code       = st;
    d.known                  = 1'b0;
    d.want                   = '0;
    d.hold                   = '0;
    d.delay                  = '0;
    return d;
  endfunction

  function automatic dir_row_t row_known(input logic [1:0] op, input logic [1:0] st,
                                         input logic [1:0] act, input logic hd);
    dir_row_t d;
    d                  = row(op, 1'b0, st);
    d.known            = 1'b1;
    d.want.action      = act;
    d.want.object_held = hd;
    return d;
  endfunction

  function automatic dir_row_t row_regs(input logic [7:0] h, input logic [7:0] dl);
    dir_row_t d;
    d       = row(bhct_pkg::OP_NONE, 1'b0, 2'd0);
    d.kind  = ROW_REGS;
    d.hold  = h;
    d.delay = dl;
    return d;
  endfunction

  // output side: random stalls unless in a quiet phase
  always @(posedge clk) begin
    if (sink_stall != 0) begin
      sink_ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) sink_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_actions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: action %0d object_held %0b", $time,
                 out_ch.data.action, out_ch.data.object_held);
      end else begin
        seen_want = pending_actions.pop_front();
        if (out_ch.data.action != seen_want.action) begin
          errors++;
          $display("%0t: action mismatch: expected %0d, actual %0d", $time,
                   seen_want.action, out_ch.data.action);
        end
        if (out_ch.data.object_held != seen_want.object_held) begin
          errors++;
          $display("%0t: object_held mismatch: expected %0b, actual %0b", $time,
                   seen_want.object_held, out_ch.data.object_held);
        end
      end
    end
  end

  // one input transaction; called at a clock edge, returns at its acceptance
  task automatic send_txn(input bhct_pkg::in_item_t it, input bit known,
                          input bhct_pkg::out_item_t want);
    int unsigned         gap;
    bit                  hold_off;
    bhct_pkg::out_item_t pred;
    gap      = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    hold_off = (!quiet && $urandom_range(0, 63) == 0);
    if (hold_off && gap == 0) gap = 1;
    if (gap != 0) begin
      src_valid <= 1'b0;
      while (hold_off && pending_actions.size() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pred = advance_trigger(it);
    pending_actions.push_back(known ? want : pred);
  endtask

  task automatic play(input bhct_pkg::in_item_t it);
    send_txn(it, 1'b0, '0);
    if (it.opcode != bhct_pkg::OP_NONE) played++;
  endtask

  task automatic set_ticks(input logic [7:0] h, input logic [7:0] dl);
    src_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bhct_pkg::REG_HOLD_TICKS;
    cfg_wdata <= h;
    @(posedge clk);
    hold_reg   = h;
    cfg_index <= bhct_pkg::REG_DELAY_TICKS;
    cfg_wdata <= dl;
    @(posedge clk);
    delay_reg = dl;
    cfg_we   <= 1'b0;
  endtask

  // close, hold (sometimes too briefly), reopen, wait for the command, then report back
  task automatic play_blink_hold();
    int unsigned n;
    bit          abort_early;
    abort_early = ($urandom_range(0, 5) == 0);
    play(mk(bhct_pkg::OP_BLINK, 1'b1));
    n = abort_early ? $urandom_range(0, hold_reg) : 1 + hold_reg + $urandom_range(0, 2);
    repeat (n) begin
      play(mk(bhct_pkg::OP_TICK, 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 15) == 0) play(mk(bhct_pkg::OP_BLINK, 1'b1));
    end
    play(mk(bhct_pkg::OP_BLINK, 1'b0));
    n = 1 + delay_reg + $urandom_range(0, 3);
    repeat (n) begin
      play(mk(bhct_pkg::OP_TICK, 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 15) == 0) begin
        play(mk(bhct_pkg::OP_BLINK, 1'($urandom_range(0, 1))));
      end
    end
    play(mk(bhct_pkg::OP_STATUS, 1'($urandom_range(0, 1))));
  endtask

  initial begin : main
    dir_row_t    dir_rows[$];
    logic [7:0]  h, dl;
    int unsigned quota;

    hold_reg    = HOLD_RESET;
    delay_reg   = DELAY_RESET;
    eye_closed  = 1'b0;
    blink_seen  = 1'b0;
    hold_run    = 1'b0;
    beep_given  = 1'b0;
    cmd_pending = 1'b0;
    held        = 1'b0;
    busy        = 1'b0;
    hold_cnt    = '0;
    delay_cnt   = '0;
    errors      = 0;
    quiet       = 1'b0;

    // reset values, status codes and the ignored opcode
    dir_rows.push_back(row_known(bhct_pkg::OP_TICK, 2'd0,
                                 bhct_pkg::ACT_NONE, 1'b0));
    dir_rows.push_back(row_known(bhct_pkg::OP_STATUS, bhct_pkg::ST_PICK_OK,
                                 bhct_pkg::ACT_NONE, 1'b1));
    dir_rows.push_back(row_known(bhct_pkg::OP_STATUS, bhct_pkg::ST_PLACE_OK,
                                 bhct_pkg::ACT_NONE, 1'b0));
    dir_rows.push_back(row_known(bhct_pkg::OP_STATUS, ST_FAILED,
                                 bhct_pkg::ACT_NONE, 1'b0));
    dir_rows.push_back(row_known(bhct_pkg::OP_STATUS, ST_SPARE,
                                 bhct_pkg::ACT_NONE, 1'b0));
    dir_rows.push_back(row_known(bhct_pkg::OP_NONE, ST_SPARE,
                                 bhct_pkg::ACT_NONE, 1'b0));
    // shortest hold and delay: beep, reopen, pick, then ignored while busy
    dir_rows.push_back(row_regs(8'd1, 8'd1));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b1, ST_SPARE));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b1, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b1, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, ST_SPARE));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b1, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_STATUS, 1'b1, bhct_pkg::ST_PICK_OK));
    // zero registers: comparison met at the first counted tick, place command
    dir_rows.push_back(row_regs(8'd0, 8'd0));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b1, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_BLINK,  1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_TICK,   1'b0, 2'd0));
    dir_rows.push_back(row(bhct_pkg::OP_STATUS, 1'b0, bhct_pkg::ST_PLACE_OK));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REGS) begin
        set_ticks(dir_rows[i].hold, dir_rows[i].delay);
      end else begin
        send_txn(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
      end
    end

    // quotas are floors; a long hold/delay sequence overshoots them
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin h = HOLD_RESET; dl = DELAY_RESET; quota = 100; end
        1: begin h = 8'd1;   dl = 8'd1;   quota = 200; end
        2: begin h = 8'd255; dl = 8'd255; quota = 450; end
        3: begin h = 8'd0;   dl = 8'd0;   quota = 100; end
        4: begin
          h = 8'($urandom_range(1, 8)); dl = 8'($urandom_range(1, 8)); quota = 150;
        end
        5: begin
          h = 8'($urandom_range(2, 12)); dl = 8'($urandom_range(2, 12)); quota = 150;
        end
        default: begin h = 8'd1; dl = 8'd255; quota = 100; end
      endcase
      quiet = (p == 3);
      set_ticks(h, dl);
      played = 0;
      while (played < quota) begin
        if ($urandom_range(0, 9) < 7) begin
          play_blink_hold();
        end else begin
          repeat ($urandom_range(1, 6))
            play(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end
      end
    end

    src_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_actions.size() == 0) begin
      $display("blink_hold_command_trigger_tb OK");
    end else begin
      $display("blink_hold_command_trigger_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_actions.size());
    $display("blink_hold_command_trigger_tb NOT OK");
    $finish;
  end

endmodule
